// File: hdl/xie_pkg.sv
package xie_pkg;

    // Longest instruction: REX + opcode + imm64
    localparam int MAX_BYTES   = 10;
    localparam int LEN_W       = 4;
    localparam int QUEUE_DEPTH = 2;

    // Form selector codes
    typedef enum logic [4:0] {
        F_MOV_RR, F_MOV_RI, F_MOV_ABS, F_STORE, F_LOAD, F_PUSH, F_POP, F_ADD_RR,
        F_ADD_RI, F_SUB_RR, F_SUB_RI, F_CMP_RR, F_CMP_RI, F_JMP, F_JE, F_JNE,
        F_JL, F_JG, F_JLE, F_JGE, F_JMP_IND, F_CALL_IND, F_RET, F_MOVSD,
        F_ADDSD, F_SUBSD, F_MULSD, F_DIVSD, F_CVTSI2SD, F_CVTTSD2SI, F_UCOMISD, F_XORPD
    } func_t;

    // Opcode and prefix bytes
    localparam logic [7:0] REX_BASE    = 8'h40;
    localparam logic [7:0] REX_B_ONLY  = 8'h41;
    localparam logic [7:0] OP_MOV_MR   = 8'h89;
    localparam logic [7:0] OP_MOV_RM   = 8'h8B;
    localparam logic [7:0] OP_ADD_MR   = 8'h01;
    localparam logic [7:0] OP_SUB_MR   = 8'h29;
    localparam logic [7:0] OP_CMP_MR   = 8'h39;
    localparam logic [7:0] OP_MOV_IMM  = 8'hC7;
    localparam logic [7:0] OP_ALU_IMM  = 8'h81;
    localparam logic [7:0] OP_MOV_ABS  = 8'hB8;
    localparam logic [7:0] OP_PUSH     = 8'h50;
    localparam logic [7:0] OP_POP      = 8'h58;
    localparam logic [7:0] OP_JMP_REL  = 8'hE9;
    localparam logic [7:0] OP_ESCAPE   = 8'h0F;
    localparam logic [7:0] OP_GRP5     = 8'hFF;
    localparam logic [7:0] OP_RET      = 8'hC3;
    localparam logic [7:0] PFX_SD      = 8'hF2;
    localparam logic [7:0] PFX_OPSIZE  = 8'h66;
    localparam logic [7:0] SIB_NO_IDX  = 8'h24;
    localparam logic [7:0] DISP8_ZERO  = 8'h00;

    // ModRM reg-field extensions
    localparam logic [2:0] EXT_ADD  = 3'd0;
    localparam logic [2:0] EXT_SUB  = 3'd5;
    localparam logic [2:0] EXT_CMP  = 3'd7;
    localparam logic [2:0] EXT_CALL = 3'd2;
    localparam logic [2:0] EXT_JMP  = 3'd4;
    localparam logic [1:0] MOD_REG  = 2'b11;
    localparam logic [1:0] MOD_IND  = 2'b00;
    localparam logic [1:0] MOD_D8   = 2'b01;

    // One encoded instruction, byte 0 is emitted first
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [LEN_W-1:0]          len;
    } entry_t;

endpackage

// File: hdl/xie_front.sv
module xie_front
(
    input  logic [4:0]      func,
    input  logic [3:0]      dst_reg,
    input  logic [3:0]      src_reg,
    input  logic [63:0]     immediate,
    output xie_pkg::entry_t entry
);

    function automatic logic [7:0] rex_byte(input logic w, input logic [3:0] r,
                                            input logic [3:0] b);
        return {4'h4, w, r[3], 1'b0, b[3]};
    endfunction

    function automatic logic [7:0] modrm(input logic [1:0] md, input logic [2:0] rg,
                                         input logic [2:0] rm);
        return {md, rg, rm};
    endfunction

    function automatic logic [7:0] jcc_op(input xie_pkg::func_t f);
        case (f)
            xie_pkg::F_JE:  return 8'h84;
            xie_pkg::F_JNE: return 8'h85;
            xie_pkg::F_JL:  return 8'h8C;
            xie_pkg::F_JG:  return 8'h8F;
            xie_pkg::F_JLE: return 8'h8E;
            default:        return 8'h8D;
        endcase
    endfunction

    function automatic logic [7:0] sse_op(input xie_pkg::func_t f);
        case (f)
            xie_pkg::F_MOVSD:     return 8'h10;
            xie_pkg::F_ADDSD:     return 8'h58;
            xie_pkg::F_SUBSD:     return 8'h5C;
            xie_pkg::F_MULSD:     return 8'h59;
            xie_pkg::F_DIVSD:     return 8'h5E;
            xie_pkg::F_CVTSI2SD:  return 8'h2A;
            xie_pkg::F_CVTTSD2SI: return 8'h2C;
            xie_pkg::F_UCOMISD:   return 8'h2E;
            default:              return 8'h57;
        endcase
    endfunction

    xie_pkg::func_t f;
    logic [3:0]     base;
    logic [3:0]     rg;
    logic [7:0]     op;
    logic [7:0]     mr;
    logic [2:0]     ext;
    logic           wide;
    logic           need_rex;

    assign f = xie_pkg::func_t'(func);

    // Encode one request into its byte string
    always_comb
    begin
        entry    = '0;
        base     = (f == xie_pkg::F_STORE) ? dst_reg : src_reg;
        rg       = (f == xie_pkg::F_STORE) ? src_reg : dst_reg;
        op       = '0;
        mr       = '0;
        ext      = '0;
        wide     = (f == xie_pkg::F_CVTSI2SD) || (f == xie_pkg::F_CVTTSD2SI);
        need_rex = wide || dst_reg[3] || src_reg[3];
        case (f)
            xie_pkg::F_MOV_RR, xie_pkg::F_ADD_RR, xie_pkg::F_SUB_RR, xie_pkg::F_CMP_RR:
            begin
                op = (f == xie_pkg::F_MOV_RR) ? xie_pkg::OP_MOV_MR :
                     (f == xie_pkg::F_ADD_RR) ? xie_pkg::OP_ADD_MR :
                     (f == xie_pkg::F_SUB_RR) ? xie_pkg::OP_SUB_MR : xie_pkg::OP_CMP_MR;
                entry.bytes[0] = rex_byte(1'b1, src_reg, dst_reg);
                entry.bytes[1] = op;
                entry.bytes[2] = modrm(xie_pkg::MOD_REG, src_reg[2:0], dst_reg[2:0]);
                entry.len      = xie_pkg::LEN_W'(3);
            end
            xie_pkg::F_MOV_RI, xie_pkg::F_ADD_RI, xie_pkg::F_SUB_RI, xie_pkg::F_CMP_RI:
            begin
                ext = (f == xie_pkg::F_SUB_RI) ? xie_pkg::EXT_SUB :
                      (f == xie_pkg::F_CMP_RI) ? xie_pkg::EXT_CMP : xie_pkg::EXT_ADD;
                entry.bytes[0] = rex_byte(1'b1, 4'd0, dst_reg);
                entry.bytes[1] = (f == xie_pkg::F_MOV_RI) ? xie_pkg::OP_MOV_IMM
                                                          : xie_pkg::OP_ALU_IMM;
                entry.bytes[2] = modrm(xie_pkg::MOD_REG, ext, dst_reg[2:0]);
                for (int i = 0; i < 4; i++)
                begin
                    entry.bytes[3 + i] = immediate[8*i +: 8];
                end
                entry.len = xie_pkg::LEN_W'(7);
            end
            xie_pkg::F_MOV_ABS:
            begin
                entry.bytes[0] = rex_byte(1'b1, 4'd0, dst_reg);
                entry.bytes[1] = xie_pkg::OP_MOV_ABS | {5'd0, dst_reg[2:0]};
                for (int i = 0; i < 8; i++)
                begin
                    entry.bytes[2 + i] = immediate[8*i +: 8];
                end
                entry.len = xie_pkg::LEN_W'(10);
            end
            xie_pkg::F_STORE, xie_pkg::F_LOAD:
            begin
                // rsp/r12 need a SIB byte, rbp/r13 need a zero disp8
                entry.bytes[0] = rex_byte(1'b1, rg, base);
                entry.bytes[1] = (f == xie_pkg::F_STORE) ? xie_pkg::OP_MOV_MR
                                                         : xie_pkg::OP_MOV_RM;
                entry.bytes[2] = modrm((base[2:0] == 3'd5) ? xie_pkg::MOD_D8
                                                           : xie_pkg::MOD_IND,
                                       rg[2:0], base[2:0]);
                if (base[2:0] == 3'd4)
                begin
                    entry.bytes[3] = xie_pkg::SIB_NO_IDX;
                    entry.len      = xie_pkg::LEN_W'(4);
                end
                else if (base[2:0] == 3'd5)
                begin
                    entry.bytes[3] = xie_pkg::DISP8_ZERO;
                    entry.len      = xie_pkg::LEN_W'(4);
                end
                else
                begin
                    entry.len = xie_pkg::LEN_W'(3);
                end
            end
            xie_pkg::F_PUSH, xie_pkg::F_POP:
            begin
                op = ((f == xie_pkg::F_PUSH) ? xie_pkg::OP_PUSH : xie_pkg::OP_POP)
                     | {5'd0, dst_reg[2:0]};
                if (dst_reg[3])
                begin
                    entry.bytes[0] = xie_pkg::REX_B_ONLY;
                    entry.bytes[1] = op;
                    entry.len      = xie_pkg::LEN_W'(2);
                end
                else
                begin
                    entry.bytes[0] = op;
                    entry.len      = xie_pkg::LEN_W'(1);
                end
            end
            xie_pkg::F_JMP:
            begin
                entry.bytes[0] = xie_pkg::OP_JMP_REL;
                for (int i = 0; i < 4; i++)
                begin
                    entry.bytes[1 + i] = immediate[8*i +: 8];
                end
                entry.len = xie_pkg::LEN_W'(5);
            end
            xie_pkg::F_JE, xie_pkg::F_JNE, xie_pkg::F_JL, xie_pkg::F_JG,
            xie_pkg::F_JLE, xie_pkg::F_JGE:
            begin
                entry.bytes[0] = xie_pkg::OP_ESCAPE;
                entry.bytes[1] = jcc_op(f);
                for (int i = 0; i < 4; i++)
                begin
                    entry.bytes[2 + i] = immediate[8*i +: 8];
                end
                entry.len = xie_pkg::LEN_W'(6);
            end
            xie_pkg::F_JMP_IND, xie_pkg::F_CALL_IND:
            begin
                mr = modrm(xie_pkg::MOD_REG,
                           (f == xie_pkg::F_JMP_IND) ? xie_pkg::EXT_JMP : xie_pkg::EXT_CALL,
                           dst_reg[2:0]);
                if (dst_reg[3])
                begin
                    entry.bytes[0] = xie_pkg::REX_B_ONLY;
                    entry.bytes[1] = xie_pkg::OP_GRP5;
                    entry.bytes[2] = mr;
                    entry.len      = xie_pkg::LEN_W'(3);
                end
                else
                begin
                    entry.bytes[0] = xie_pkg::OP_GRP5;
                    entry.bytes[1] = mr;
                    entry.len      = xie_pkg::LEN_W'(2);
                end
            end
            xie_pkg::F_RET:
            begin
                entry.bytes[0] = xie_pkg::OP_RET;
                entry.len      = xie_pkg::LEN_W'(1);
            end
            default:
            begin
                // Double-precision SSE forms
                op = ((f == xie_pkg::F_UCOMISD) || (f == xie_pkg::F_XORPD))
                     ? xie_pkg::PFX_OPSIZE : xie_pkg::PFX_SD;
                mr = modrm(xie_pkg::MOD_REG, dst_reg[2:0], src_reg[2:0]);
                entry.bytes[0] = op;
                if (need_rex)
                begin
                    entry.bytes[1] = rex_byte(wide, dst_reg, src_reg);
                    entry.bytes[2] = xie_pkg::OP_ESCAPE;
                    entry.bytes[3] = sse_op(f);
                    entry.bytes[4] = mr;
                    entry.len      = xie_pkg::LEN_W'(5);
                end
                else
                begin
                    entry.bytes[1] = xie_pkg::OP_ESCAPE;
                    entry.bytes[2] = sse_op(f);
                    entry.bytes[3] = mr;
                    entry.len      = xie_pkg::LEN_W'(4);
                end
            end
        endcase
    end

endmodule

// File: hdl/xie_queue.sv
module xie_queue
#(
    parameter int DEPTH = xie_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  xie_pkg::entry_t push_entry,
    output logic            has_room,
    input  logic            pop,
    output logic            has_entry,
    output xie_pkg::entry_t pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    xie_pkg::entry_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign has_room  = (count_reg != CNT_W'(DEPTH));
    assign has_entry = (count_reg != '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Fill count never exceeds depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    // Pointers are equal while the queue is empty
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers differ while empty");

endmodule

// File: hdl/xie_back.sv
module xie_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            has_entry,
    input  xie_pkg::entry_t head_entry,
    output logic            take,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      code_byte,
    output logic            last_byte
);

    logic [xie_pkg::MAX_BYTES-1:0][7:0] bytes_reg;
    logic [xie_pkg::MAX_BYTES-1:0][7:0] bytes_next;
    logic [xie_pkg::LEN_W-1:0]          left_reg;
    logic [xie_pkg::LEN_W-1:0]          left_next;
    logic                               cur_valid_reg;
    logic                               cur_valid_next;
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic [7:0]                         code_byte_reg;
    logic [7:0]                         code_byte_next;
    logic                               last_byte_reg;
    logic                               last_byte_next;
    logic                               emit;
    logic                               final_emit;

    assign emit       = cur_valid_reg && (!out_valid_reg || out_ready);
    assign final_emit = emit && (left_reg == xie_pkg::LEN_W'(1));
    assign take       = has_entry && (!cur_valid_reg || final_emit);

    assign out_valid = out_valid_reg;
    assign code_byte = code_byte_reg;
    assign last_byte = last_byte_reg;

    // Byte shifter and output register
    always_comb
    begin
        bytes_next     = bytes_reg;
        left_next      = left_reg;
        cur_valid_next = cur_valid_reg;
        out_valid_next = out_valid_reg;
        code_byte_next = code_byte_reg;
        last_byte_next = last_byte_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            code_byte_next = bytes_reg[0];
            last_byte_next = (left_reg == xie_pkg::LEN_W'(1));
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (take)
        begin
            bytes_next     = head_entry.bytes;
            left_next      = head_entry.len;
            cur_valid_next = 1'b1;
        end
        else if (emit)
        begin
            bytes_next     = {8'h00, bytes_reg[xie_pkg::MAX_BYTES-1:1]};
            left_next      = left_reg - 1'b1;
            cur_valid_next = !final_emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg     <= bytes_next;
        left_reg      <= left_next;
        code_byte_reg <= code_byte_next;
        last_byte_reg <= last_byte_next;
    end

    // A held instruction always has bytes left, within the longest form
    a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (left_reg != '0) && (left_reg <= xie_pkg::LEN_W'(xie_pkg::MAX_BYTES)))
        else $error("byte count out of range");

    // Final byte with nothing queued leaves the shifter empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (final_emit && !has_entry) |=> !cur_valid_reg)
        else $error("shifter not empty after final byte");

endmodule

// File: hdl/x86_64_instruction_encoder.sv
// Channel   Signals                                      Direction  Handshake
// request   func, dst_reg, src_reg, immediate            in         in_valid / in_ready
// code      code_byte, last_byte                         out        out_valid / out_ready
//
// One code byte leaves per cycle unless the output stalls; an instruction of
// 1 to 10 bytes holds the byte shifter until its last byte leaves. A request is
// encoded in the cycle it is accepted; its first byte passes the queue slot, the
// shifter and the output register. The queue (QUEUE_DEPTH entries) takes requests
// while the shifter works or the output stalls. Reset clears the queue and valid flags.
module x86_64_instruction_encoder
#(
    parameter int QUEUE_DEPTH = xie_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [4:0]  func,
    input  logic [3:0]  dst_reg,
    input  logic [3:0]  src_reg,
    input  logic [63:0] immediate,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  code_byte,
    output logic        last_byte
);

    xie_pkg::entry_t enc_entry;
    xie_pkg::entry_t head_entry;
    logic            has_room;
    logic            has_entry;
    logic            take;

    assign in_ready = has_room;

    // Encoder
    xie_front u_front
    (
        .func      (func),
        .dst_reg   (dst_reg),
        .src_reg   (src_reg),
        .immediate (immediate),
        .entry     (enc_entry)
    );

    // Request queue
    xie_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_valid && has_room),
        .push_entry (enc_entry),
        .has_room   (has_room),
        .pop        (take),
        .has_entry  (has_entry),
        .pop_entry  (head_entry)
    );

    // Byte emitter
    xie_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .has_entry  (has_entry),
        .head_entry (head_entry),
        .take       (take),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_byte  (code_byte),
        .last_byte  (last_byte)
    );

endmodule
